// ----- sv/sbsi_pkg.sv -----
package sbsi_pkg;

    // Field and datapath widths.
    localparam int COORD_W = 24;
    localparam int FRAC_W  = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int MAG_W   = DIFF_W;
    localparam int Q_W     = FRAC_W + 1;
    localparam int FR_W    = FRAC_W + 3;
    localparam int NUM_FIELDS = 8;
    localparam int S_DATA_W = ((NUM_FIELDS * COORD_W + 7) / 8) * 8;
    localparam int M_DATA_W = 8;

    // Window bounds in the fraction format.  Fractions above one are
    // collapsed to ONE + 1, and negative ones to minus one unit, because the
    // window never leaves [0, 1].
    localparam logic signed [FR_W-1:0] FR_ZERO  = '0;
    localparam logic signed [FR_W-1:0] FR_ONE   = FR_W'(1 << FRAC_W);
    localparam logic signed [FR_W-1:0] FR_OVER  = FR_W'((1 << FRAC_W) + 1);
    localparam logic signed [FR_W-1:0] FR_UNDER = '1;

    // One slab plane of one axis, as a signed quotient to be formed.
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] num_mag;
    } sbsi_plane_t;

    // One axis after classification.
    typedef struct packed {
        logic             par;
        logic             par_in;
        logic [MAG_W-1:0] den_mag;
        sbsi_plane_t      lo;
        sbsi_plane_t      hi;
    } sbsi_axis_t;

    typedef struct packed {
        sbsi_axis_t x;
        sbsi_axis_t y;
    } sbsi_item_t;

endpackage

// ----- sv/sbsi_front.sv -----
module sbsi_front (
    input  logic [sbsi_pkg::COORD_W-1:0] start_x,
    input  logic [sbsi_pkg::COORD_W-1:0] start_y,
    input  logic [sbsi_pkg::COORD_W-1:0] end_x,
    input  logic [sbsi_pkg::COORD_W-1:0] end_y,
    input  logic [sbsi_pkg::COORD_W-1:0] box_x_min,
    input  logic [sbsi_pkg::COORD_W-1:0] box_x_max,
    input  logic [sbsi_pkg::COORD_W-1:0] box_y_min,
    input  logic [sbsi_pkg::COORD_W-1:0] box_y_max,
    output sbsi_pkg::sbsi_item_t         item
);

    function automatic logic signed [sbsi_pkg::DIFF_W-1:0] diff(
        input logic [sbsi_pkg::COORD_W-1:0] a,
        input logic [sbsi_pkg::COORD_W-1:0] b
    );
        logic signed [sbsi_pkg::DIFF_W-1:0] ea;
        logic signed [sbsi_pkg::DIFF_W-1:0] eb;
        ea = {a[sbsi_pkg::COORD_W-1], a};
        eb = {b[sbsi_pkg::COORD_W-1], b};
        return ea - eb;
    endfunction

    function automatic logic [sbsi_pkg::MAG_W-1:0] mag(
        input logic signed [sbsi_pkg::DIFF_W-1:0] v
    );
        return v[sbsi_pkg::DIFF_W-1] ? sbsi_pkg::MAG_W'(-v) : sbsi_pkg::MAG_W'(v);
    endfunction

    // Classify one axis: differences, magnitudes, quotient signs and the
    // parallel test (start between the bounds, in either order).
    function automatic sbsi_pkg::sbsi_axis_t classify(
        input logic [sbsi_pkg::COORD_W-1:0] s,
        input logic [sbsi_pkg::COORD_W-1:0] e,
        input logic [sbsi_pkg::COORD_W-1:0] bmin,
        input logic [sbsi_pkg::COORD_W-1:0] bmax
    );
        sbsi_pkg::sbsi_axis_t r;
        logic signed [sbsi_pkg::DIFF_W-1:0] d;
        logic signed [sbsi_pkg::DIFF_W-1:0] nlo;
        logic signed [sbsi_pkg::DIFF_W-1:0] nhi;
        d   = diff(e, s);
        nlo = diff(bmin, s);
        nhi = diff(bmax, s);
        r.par        = (d == '0);
        r.par_in     = ((nlo <= 0) && (nhi >= 0)) || ((nhi <= 0) && (nlo >= 0));
        r.den_mag    = mag(d);
        r.lo.num_mag = mag(nlo);
        r.lo.neg     = nlo[sbsi_pkg::DIFF_W-1] ^ d[sbsi_pkg::DIFF_W-1];
        r.hi.num_mag = mag(nhi);
        r.hi.neg     = nhi[sbsi_pkg::DIFF_W-1] ^ d[sbsi_pkg::DIFF_W-1];
        return r;
    endfunction

    assign item.x = classify(start_x, end_x, box_x_min, box_x_max);
    assign item.y = classify(start_y, end_y, box_y_min, box_y_max);

endmodule

// ----- sv/sbsi_fifo.sv -----
module sbsi_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  sbsi_pkg::sbsi_item_t push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output sbsi_pkg::sbsi_item_t pop_data
);

    sbsi_pkg::sbsi_item_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    // Pointer and fill count.
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Item storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3) else $error("queue count out of range");
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg != 2'd2) || pop) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != 2'd0) else $error("queue underflow");
`endif

endmodule

// ----- sv/sbsi_div.sv -----
module sbsi_div (
    input  logic                               aclk,
    input  logic                               en,
    input  sbsi_pkg::sbsi_plane_t              plane,
    input  logic [sbsi_pkg::MAG_W-1:0]         den_mag,
    output logic signed [sbsi_pkg::FR_W-1:0]   frac
);

    localparam int QW = sbsi_pkg::Q_W;
    localparam int MW = sbsi_pkg::MAG_W;

    logic [MW-1:0] r_reg   [QW+1];
    logic [MW-1:0] d_reg   [QW+1];
    logic [QW-1:0] q_reg   [QW+1];
    logic          neg_reg [QW+1];
    logic          ovf_reg [QW+1];
    logic          b0_reg;

    // Stage 0: a quotient of two or more saturates; otherwise it has QW bits.
    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]   <= {1'b0, plane.num_mag[MW-1:1]};
            b0_reg     <= plane.num_mag[0];
            d_reg[0]   <= den_mag;
            q_reg[0]   <= '0;
            neg_reg[0] <= plane.neg;
            ovf_reg[0] <= {1'b0, plane.num_mag} >= {den_mag, 1'b0};
        end
    end

    // One restoring step per stage, quotient bits from the top down.
    for (genvar i = 1; i <= QW; i++) begin : g_step
        localparam int K = QW - i;
        logic [MW:0] sh;
        logic [MW:0] sub;
        assign sh  = {r_reg[i-1], (K == sbsi_pkg::FRAC_W) ? b0_reg : 1'b0};
        assign sub = sh - {1'b0, d_reg[i-1]};
        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[i]   <= sub[MW] ? sh[MW-1:0] : sub[MW-1:0];
                q_reg[i]   <= q_reg[i-1] | (QW'(!sub[MW]) << K);
                d_reg[i]   <= d_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
                ovf_reg[i] <= ovf_reg[i-1];
            end
        end
    end

    // Collapse to the window's range: a negative non-zero quotient is minus
    // one unit, anything beyond one plus one unit is one plus one unit.
    always_comb begin
        if (neg_reg[QW]) begin
            frac = (q_reg[QW] == '0) ? sbsi_pkg::FR_ZERO : sbsi_pkg::FR_UNDER;
        end else if (ovf_reg[QW] || ({2'b00, q_reg[QW]} > sbsi_pkg::FR_OVER)) begin
            frac = sbsi_pkg::FR_OVER;
        end else begin
            frac = {2'b00, q_reg[QW]};
        end
    end

endmodule

// ----- sv/sbsi_back.sv -----
module sbsi_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  sbsi_pkg::sbsi_item_t in_item,
    output logic                 in_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic                 hit
);

    localparam int QW = sbsi_pkg::Q_W;

    typedef struct packed {
        logic par;
        logic par_in;
    } par_t;

    typedef struct packed {
        logic                             ok;
        logic signed [sbsi_pkg::FR_W-1:0] lo;
        logic signed [sbsi_pkg::FR_W-1:0] hi;
    } win_t;

    logic en;
    logic v_reg   [QW+1];
    par_t px_reg  [QW+1];
    par_t py_reg  [QW+1];
    logic signed [sbsi_pkg::FR_W-1:0] fx_lo;
    logic signed [sbsi_pkg::FR_W-1:0] fx_hi;
    logic signed [sbsi_pkg::FR_W-1:0] fy_lo;
    logic signed [sbsi_pkg::FR_W-1:0] fy_hi;
    logic signed [sbsi_pkg::FR_W-1:0] yl_reg;
    logic signed [sbsi_pkg::FR_W-1:0] yh_reg;
    par_t py_x_reg;
    win_t wx_reg;
    win_t wx_next;
    win_t wy_next;
    logic vx_reg;
    logic m_tvalid_reg;
    logic hit_reg;

    // The whole pipeline moves unless a finished item waits at the output.
    assign en       = !m_tvalid_reg || m_tready;
    assign in_pop   = en && in_valid;
    assign m_tvalid = m_tvalid_reg;
    assign hit      = hit_reg;

    // Clip the window against one axis's two fractions.
    function automatic win_t clip(
        input win_t                             w,
        input par_t                             p,
        input logic signed [sbsi_pkg::FR_W-1:0] a,
        input logic signed [sbsi_pkg::FR_W-1:0] b
    );
        win_t r;
        logic signed [sbsi_pkg::FR_W-1:0] flo;
        logic signed [sbsi_pkg::FR_W-1:0] fhi;
        flo = (b < a) ? b : a;
        fhi = (b < a) ? a : b;
        r = w;
        if (p.par) begin
            r.ok = w.ok && p.par_in;
        end else if ((fhi < w.lo) || (flo > w.hi)) begin
            r.ok = 1'b0;
        end else begin
            r.lo = (flo > w.lo) ? flo : w.lo;
            r.hi = (fhi < w.hi) ? fhi : w.hi;
            r.ok = w.ok && (r.lo <= r.hi);
        end
        return r;
    endfunction

    // Four quotient lanes share the stall.
    sbsi_div u_div_xl (.aclk(aclk), .en(en), .plane(in_item.x.lo),
                       .den_mag(in_item.x.den_mag), .frac(fx_lo));
    sbsi_div u_div_xh (.aclk(aclk), .en(en), .plane(in_item.x.hi),
                       .den_mag(in_item.x.den_mag), .frac(fx_hi));
    sbsi_div u_div_yl (.aclk(aclk), .en(en), .plane(in_item.y.lo),
                       .den_mag(in_item.y.den_mag), .frac(fy_lo));
    sbsi_div u_div_yh (.aclk(aclk), .en(en), .plane(in_item.y.hi),
                       .den_mag(in_item.y.den_mag), .frac(fy_hi));

    // Valid bits and parallel flags alongside the quotient lanes.
    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg[0] <= '{par: in_item.x.par, par_in: in_item.x.par_in};
            py_reg[0] <= '{par: in_item.y.par, par_in: in_item.y.par_in};
            for (int i = 1; i <= QW; i++) begin
                px_reg[i] <= px_reg[i-1];
                py_reg[i] <= py_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= QW; i++) begin
                v_reg[i] <= 1'b0;
            end
            vx_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int i = 1; i <= QW; i++) begin
                v_reg[i] <= v_reg[i-1];
            end
            vx_reg       <= v_reg[QW];
            m_tvalid_reg <= vx_reg;
        end
    end

    // X axis against the starting window, then y against what x leaves.
    assign wx_next = clip('{ok: 1'b1, lo: sbsi_pkg::FR_ZERO, hi: sbsi_pkg::FR_ONE},
                          px_reg[QW], fx_lo, fx_hi);
    assign wy_next = clip(wx_reg, py_x_reg, yl_reg, yh_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            wx_reg   <= wx_next;
            py_x_reg <= py_reg[QW];
            yl_reg   <= fy_lo;
            yh_reg   <= fy_hi;
            hit_reg  <= wy_next.ok;
        end
    end

endmodule

// ----- sv/segment_box_slab_intersect.sv -----
// Segment versus axis-aligned box test by the slab method.
// Input channel s_*: one item per handshake, a segment (start, end) and a box,
// all signed Q16.8 coordinates packed into s_tdata.  Result channel m_*: one
// item per input item, in order, carrying the hit flag in m_tdata bit 0.
// From the edge that accepts an input item to the edge that raises m_tvalid,
// the item passes the two-entry queue behind the classifier, a register that
// tests for quotient saturation, the restoring division (one quotient bit per
// stage, four lanes side by side) and the x window clip register; the y clip
// feeds the output register.
// Throughput is one item per cycle while the result channel does not stall; the
// division pipeline is the longest part of the path and sets the latency.
// When a result waits and m_tready is low, the back pipeline holds, the queue
// fills, and s_tready falls once both queue entries are taken; an item waiting on
// the result channel does not block acceptance until then.
// A synchronous active-low reset empties the queue and clears all valid bits;
// no result is pending after reset.
module segment_box_slab_intersect (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // start_x, start_y, end_x, end_y, box_x_min, box_x_max, box_y_min, box_y_max
    input  logic [sbsi_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // hit, then zero padding
    output logic [sbsi_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int CW = sbsi_pkg::COORD_W;

    sbsi_pkg::sbsi_item_t front_item;
    sbsi_pkg::sbsi_item_t queue_item;
    logic push;
    logic full;
    logic pop;
    logic not_empty;
    logic hit;

    sbsi_front u_front (
        .start_x  (s_tdata[0*CW +: CW]),
        .start_y  (s_tdata[1*CW +: CW]),
        .end_x    (s_tdata[2*CW +: CW]),
        .end_y    (s_tdata[3*CW +: CW]),
        .box_x_min(s_tdata[4*CW +: CW]),
        .box_x_max(s_tdata[5*CW +: CW]),
        .box_y_min(s_tdata[6*CW +: CW]),
        .box_y_max(s_tdata[7*CW +: CW]),
        .item     (front_item)
    );

    // Accept while the queue has room.
    assign s_tready = !full;
    assign push     = s_tvalid && !full;

    sbsi_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data(front_item),
        .full     (full),
        .pop      (pop),
        .not_empty(not_empty),
        .pop_data (queue_item)
    );

    sbsi_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(not_empty),
        .in_item (queue_item),
        .in_pop  (pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .hit     (hit)
    );

    assign m_tdata = {{(sbsi_pkg::M_DATA_W-1){1'b0}}, hit};

endmodule

// ----- tb/sv/segment_box_slab_intersect_test.sv -----
module segment_box_slab_intersect_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_ONE_I = 1 << sbsi_pkg::FRAC_W;
    localparam longint QSAT = (longint'(1) << (sbsi_pkg::COORD_W + sbsi_pkg::FRAC_W)) - 1;
    localparam int MAX_C = (1 << (sbsi_pkg::COORD_W - 1)) - 1;
    localparam int MIN_C = -(1 << (sbsi_pkg::COORD_W - 1));

    typedef struct packed {
        logic signed [sbsi_pkg::COORD_W-1:0] box_y_max;
        logic signed [sbsi_pkg::COORD_W-1:0] box_y_min;
        logic signed [sbsi_pkg::COORD_W-1:0] box_x_max;
        logic signed [sbsi_pkg::COORD_W-1:0] box_x_min;
        logic signed [sbsi_pkg::COORD_W-1:0] end_y;
        logic signed [sbsi_pkg::COORD_W-1:0] end_x;
        logic signed [sbsi_pkg::COORD_W-1:0] start_y;
        logic signed [sbsi_pkg::COORD_W-1:0] start_x;
    } query_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    // start_x, start_y, end_x, end_y, box_x_min, box_x_max, box_y_min, box_y_max
    logic [sbsi_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    // hit, then zero padding
    logic [sbsi_pkg::M_DATA_W-1:0] m_tdata;

    query_t pending_queries[$];
    logic   expected_hits[$];
    int     error_count = 0;
    int     hits_seen = 0;
    int     misses_seen = 0;
    int     hold_off = 0;
    bit     hold_request = 1'b0;

    segment_box_slab_intersect uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Clock with a 12 ns period.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Quotient with truncation toward zero, saturated to the fraction range.
    function automatic longint slab_fraction(longint num, longint den);
        longint q;
        q = (num * FRAC_ONE_I) / den;
        if (q > QSAT) q = QSAT;
        if (q < -QSAT) q = -QSAT;
        return q;
    endfunction

    // Narrows the window [lo, hi] against one axis; returns 0 on a miss.
    function automatic bit clip_window(longint s, longint e, longint bmin, longint bmax,
                                       inout longint lo, inout longint hi);
        longint d, flo, fhi, t;
        d = e - s;
        if (d == 0) begin
            if (bmin < bmax) return s >= bmin && s <= bmax;
            return s >= bmax && s <= bmin;
        end
        flo = slab_fraction(bmin - s, d);
        fhi = slab_fraction(bmax - s, d);
        if (fhi < flo) begin
            t = fhi; fhi = flo; flo = t;
        end
        if (fhi < lo || flo > hi) return 1'b0;
        if (flo > lo) lo = flo;
        if (fhi < hi) hi = fhi;
        return lo <= hi;
    endfunction

    function automatic bit segment_hits_box(query_t q);
        longint lo, hi;
        bit hit;
        lo = 0;
        hi = FRAC_ONE_I;
        hit = clip_window(q.start_x, q.end_x, q.box_x_min, q.box_x_max, lo, hi);
        if (hit) hit = clip_window(q.start_y, q.end_y, q.box_y_min, q.box_y_max, lo, hi);
        return hit;
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic int any_coord();
        return int'($urandom_range(0, 2 * MAX_C + 1)) + MIN_C;
    endfunction

    // Coordinate near the origin, so that segments and boxes overlap often.
    function automatic int near_coord();
        return int'($urandom_range(0, 8000)) - 4000;
    endfunction

    task automatic add_query(int sx, sy, ex, ey, x0, x1, y0, y1);
        query_t q;
        q.start_x   = sbsi_pkg::COORD_W'(sx);
        q.start_y   = sbsi_pkg::COORD_W'(sy);
        q.end_x     = sbsi_pkg::COORD_W'(ex);
        q.end_y     = sbsi_pkg::COORD_W'(ey);
        q.box_x_min = sbsi_pkg::COORD_W'(x0);
        q.box_x_max = sbsi_pkg::COORD_W'(x1);
        q.box_y_min = sbsi_pkg::COORD_W'(y0);
        q.box_y_max = sbsi_pkg::COORD_W'(y1);
        pending_queries.push_back(q);
    endtask

    // Driver: bursts of items with random gaps between them.  The item on
    // the bus stays at the head of the queue until it is accepted.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                expected_hits.push_back(segment_hits_box(pending_queries.pop_front()));
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_queries.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_queries[0];
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern, with a long hold-off on request.
    int stall_phase = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_request) begin
            hold_off <= hold_off + 1;
            m_tready <= 1'b0;
        end else begin
            stall_phase <= stall_phase + 1;
            if (stall_phase[9:8] == 2'b00) m_tready <= 1'b1;
            else m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Monitor: compares each result with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_hits.size() == 0) begin
                report_mismatch("result with no expectation");
            end else begin
                logic want;
                want = expected_hits.pop_front();
                if (m_tdata[0] !== want)
                    report_mismatch($sformatf("hit %b, expected %b", m_tdata[0], want));
                if (m_tdata[sbsi_pkg::M_DATA_W-1:1] !== '0)
                    report_mismatch("nonzero padding in result");
                if (want) hits_seen++; else misses_seen++;
            end
        end
    end

    initial begin
        int a, b, c, d;
        int k;
        // Directed: extremes, parallel axes, inverted box, touching, degenerate.
        add_query(MIN_C, MIN_C, MAX_C, MAX_C, MIN_C, MAX_C, MIN_C, MAX_C);
        add_query(MAX_C, MAX_C, MIN_C, MIN_C, 0, 0, 0, 0);
        add_query(MIN_C, 0, MAX_C, 1, -256, 256, -256, 256);
        add_query(0, MIN_C, 1, MAX_C, -256, 256, -256, 256);
        add_query(100, 100, 100, 100, 0, 200, 0, 200);
        add_query(300, 100, 300, 100, 0, 200, 0, 200);
        add_query(100, -512, 100, 512, 0, 200, 0, 200);
        add_query(100, -512, 100, 512, 200, 0, 200, 0);
        add_query(-512, 100, 512, 100, 200, 0, 0, 200);
        add_query(-512, 300, 512, 300, 0, 200, 0, 200);
        add_query(-512, -512, 0, 0, 0, 200, 0, 200);
        add_query(-512, -512, -1, -1, 0, 200, 0, 200);
        add_query(0, 0, 512, 512, 512, 1024, 512, 1024);
        add_query(0, 0, 512, 0, 512, 1024, -5, 5);
        add_query(MAX_C, MIN_C, MIN_C, MAX_C, MAX_C, MIN_C, MAX_C, MIN_C);
        add_query(MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C);
        add_query(MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C);
        add_query(-1, -1, 1, 1, 0, 0, 0, 0);
        add_query(0, 0, 1000, 1000, 400, 800, 0, 300);
        add_query(MIN_C, MIN_C, MIN_C + 1, MAX_C, MIN_C, MIN_C, 0, 1);
        add_query(-1, -1, 0, 0, -1, 0, -1, 0);
        // Random: mostly near geometry, some full-range noise.
        for (k = 0; k < 680; k++) begin
            if ($urandom_range(0, 4) == 0) begin
                add_query(any_coord(), any_coord(), any_coord(), any_coord(),
                          any_coord(), any_coord(), any_coord(), any_coord());
            end else begin
                a = near_coord(); b = near_coord(); c = near_coord(); d = near_coord();
                add_query(near_coord(), near_coord(),
                          ($urandom_range(0, 7) == 0) ? a : near_coord(),
                          ($urandom_range(0, 7) == 0) ? b : near_coord(),
                          ($urandom_range(0, 5) == 0) ? d : c,
                          ($urandom_range(0, 5) == 0) ? c : d,
                          near_coord(), near_coord());
            end
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        // Hold the receiver off for a long stretch while items keep coming.
        repeat (200) @(posedge aclk);
        hold_request <= 1'b1;
        wait (hold_off >= 150);
        @(posedge aclk);
        hold_request <= 1'b0;
        wait (pending_queries.size() == 0 && !s_tvalid);
        wait (expected_hits.size() == 0);
        repeat (40) @(posedge aclk);
        $display("Covered %0d hits and %0d misses, including extremes, parallel axes,",
                 hits_seen, misses_seen);
        $display("inverted boxes and a long receiver hold-off.");
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
sv/sbsi_pkg.sv
sv/sbsi_front.sv
sv/sbsi_fifo.sv
sv/sbsi_div.sv
sv/sbsi_back.sv
sv/segment_box_slab_intersect.sv
tb/sv/segment_box_slab_intersect_test.sv
